@@ design/rv32dec_pkg.sv @@
// Package: mnemonic codes, opcodes, CSR name codes and the decode result type.
package rv32dec_pkg;

  // Major opcodes (bits 6:0)
  localparam logic [6:0] OP_LUI    = 7'b0110111;
  localparam logic [6:0] OP_AUIPC  = 7'b0010111;
  localparam logic [6:0] OP_JAL    = 7'b1101111;
  localparam logic [6:0] OP_JALR   = 7'b1100111;
  localparam logic [6:0] OP_BRANCH = 7'b1100011;
  localparam logic [6:0] OP_LOAD   = 7'b0000011;
  localparam logic [6:0] OP_STORE  = 7'b0100011;
  localparam logic [6:0] OP_IMM    = 7'b0010011;
  localparam logic [6:0] OP_REG    = 7'b0110011;
  localparam logic [6:0] OP_FENCE  = 7'b0001111;
  localparam logic [6:0] OP_SYSTEM = 7'b1110011;

  // funct7 value that selects the multiply/divide group
  localparam logic [6:0] F7_MULDIV = 7'b0000001;

  // Upper-immediate mask
  localparam logic [31:0] UIMM_MASK = 32'hFFFFF000;

  // System funct12 codes with funct3 zero
  localparam logic [11:0] F12_ECALL  = 12'h000;
  localparam logic [11:0] F12_EBREAK = 12'h001;
  localparam logic [11:0] F12_MRET   = 12'h302;

  // Mnemonic codes
  localparam logic [5:0] MN_NONE   = 6'd0;
  localparam logic [5:0] MN_LUI    = 6'd1;
  localparam logic [5:0] MN_AUIPC  = 6'd2;
  localparam logic [5:0] MN_JAL    = 6'd3;
  localparam logic [5:0] MN_JALR   = 6'd4;
  localparam logic [5:0] MN_BEQ    = 6'd5;
  localparam logic [5:0] MN_BNE    = 6'd6;
  localparam logic [5:0] MN_BLT    = 6'd7;
  localparam logic [5:0] MN_BGE    = 6'd8;
  localparam logic [5:0] MN_BLTU   = 6'd9;
  localparam logic [5:0] MN_BGEU   = 6'd10;
  localparam logic [5:0] MN_LB     = 6'd11;
  localparam logic [5:0] MN_LH     = 6'd12;
  localparam logic [5:0] MN_LW     = 6'd13;
  localparam logic [5:0] MN_LBU    = 6'd14;
  localparam logic [5:0] MN_LHU    = 6'd15;
  localparam logic [5:0] MN_SB     = 6'd16;
  localparam logic [5:0] MN_SH     = 6'd17;
  localparam logic [5:0] MN_SW     = 6'd18;
  localparam logic [5:0] MN_ADDI   = 6'd19;
  localparam logic [5:0] MN_SLLI   = 6'd20;
  localparam logic [5:0] MN_SLTI   = 6'd21;
  localparam logic [5:0] MN_SLTIU  = 6'd22;
  localparam logic [5:0] MN_XORI   = 6'd23;
  localparam logic [5:0] MN_SRAI   = 6'd24;
  localparam logic [5:0] MN_SRLI   = 6'd25;
  localparam logic [5:0] MN_ORI    = 6'd26;
  localparam logic [5:0] MN_ANDI   = 6'd27;
  localparam logic [5:0] MN_MUL    = 6'd28;
  localparam logic [5:0] MN_MULH   = 6'd29;
  localparam logic [5:0] MN_MULHSU = 6'd30;
  localparam logic [5:0] MN_MULHU  = 6'd31;
  localparam logic [5:0] MN_DIV    = 6'd32;
  localparam logic [5:0] MN_DIVU   = 6'd33;
  localparam logic [5:0] MN_REM    = 6'd34;
  localparam logic [5:0] MN_REMU   = 6'd35;
  localparam logic [5:0] MN_SUB    = 6'd36;
  localparam logic [5:0] MN_ADD    = 6'd37;
  localparam logic [5:0] MN_SLL    = 6'd38;
  localparam logic [5:0] MN_SLT    = 6'd39;
  localparam logic [5:0] MN_SLTU   = 6'd40;
  localparam logic [5:0] MN_XOR    = 6'd41;
  localparam logic [5:0] MN_SRA    = 6'd42;
  localparam logic [5:0] MN_SRL    = 6'd43;
  localparam logic [5:0] MN_OR     = 6'd44;
  localparam logic [5:0] MN_AND    = 6'd45;
  localparam logic [5:0] MN_FENCE  = 6'd46;
  localparam logic [5:0] MN_ECALL  = 6'd47;
  localparam logic [5:0] MN_EBREAK = 6'd48;
  localparam logic [5:0] MN_MRET   = 6'd49;
  localparam logic [5:0] MN_CSRRW  = 6'd50;
  localparam logic [5:0] MN_CSRRS  = 6'd51;
  localparam logic [5:0] MN_CSRRC  = 6'd52;
  localparam logic [5:0] MN_CSRRWI = 6'd53;
  localparam logic [5:0] MN_CSRRSI = 6'd54;
  localparam logic [5:0] MN_CSRRCI = 6'd55;

  // Known CSR name codes
  localparam logic [3:0] CSRN_UNKNOWN  = 4'd0;
  localparam logic [3:0] CSRN_MSTATUS  = 4'd1;
  localparam logic [3:0] CSRN_MIE      = 4'd2;
  localparam logic [3:0] CSRN_MTVEC    = 4'd3;
  localparam logic [3:0] CSRN_MSCRATCH = 4'd4;
  localparam logic [3:0] CSRN_MEPC     = 4'd5;
  localparam logic [3:0] CSRN_MCAUSE   = 4'd6;
  localparam logic [3:0] CSRN_MTVAL    = 4'd7;
  localparam logic [3:0] CSRN_MIP      = 4'd8;
  localparam logic [3:0] CSRN_MASIC    = 4'd9;
  localparam logic [3:0] CSRN_MCYCLE   = 4'd10;
  localparam logic [3:0] CSRN_MCYCLEH  = 4'd11;

  // CSR addresses
  localparam logic [11:0] CSRA_MSTATUS  = 12'h300;
  localparam logic [11:0] CSRA_MIE      = 12'h304;
  localparam logic [11:0] CSRA_MTVEC    = 12'h305;
  localparam logic [11:0] CSRA_MSCRATCH = 12'h340;
  localparam logic [11:0] CSRA_MEPC     = 12'h341;
  localparam logic [11:0] CSRA_MCAUSE   = 12'h342;
  localparam logic [11:0] CSRA_MTVAL    = 12'h343;
  localparam logic [11:0] CSRA_MIP      = 12'h344;
  localparam logic [11:0] CSRA_MASIC    = 12'h7C0;
  localparam logic [11:0] CSRA_MCYCLE   = 12'hB00;
  localparam logic [11:0] CSRA_MCYCLEH  = 12'hB80;

  // Decoded result of one beat
  typedef struct packed {
    logic [5:0]  mnemonic;
    logic [4:0]  dest_reg;
    logic [4:0]  src1_reg;
    logic [4:0]  src2_reg;
    logic [31:0] immediate;
    logic [31:0] target;
    logic [11:0] csr_address;
    logic [3:0]  csr_name;
  } dec_result_t;

  function automatic logic [3:0] csr_index(input logic [11:0] addr);
    logic [3:0] idx;
    case (addr)
      CSRA_MSTATUS:  idx = CSRN_MSTATUS;
      CSRA_MIE:      idx = CSRN_MIE;
      CSRA_MTVEC:    idx = CSRN_MTVEC;
      CSRA_MSCRATCH: idx = CSRN_MSCRATCH;
      CSRA_MEPC:     idx = CSRN_MEPC;
      CSRA_MCAUSE:   idx = CSRN_MCAUSE;
      CSRA_MTVAL:    idx = CSRN_MTVAL;
      CSRA_MIP:      idx = CSRN_MIP;
      CSRA_MASIC:    idx = CSRN_MASIC;
      CSRA_MCYCLE:   idx = CSRN_MCYCLE;
      CSRA_MCYCLEH:  idx = CSRN_MCYCLEH;
      default:       idx = CSRN_UNKNOWN;
    endcase
    return idx;
  endfunction

endpackage

@@ design/rv32im_instruction_decoder_unit.sv @@
// Top level: registered RV32IM + Zicsr instruction decoder.
//
// Decodes one 32-bit instruction word per beat into a dense mnemonic code,
// the raw rd/rs1/rs2 fields, the format's sign-extended immediate (shamt for
// shift immediates, zimm for csrr*i), the pc-relative target for auipc, jal
// and branches, and for CSR ops the CSR address plus a known-name index.
// Unsupported words give mnemonic 0 with immediate, target and CSR fields
// zero; register fields always carry the raw bits. Decode quirks: only
// funct7 == 1 selects the M group, bit 30 alone picks sub/sra/srai, and
// opcode 0001111 is fence whatever funct3 holds. Timing: two register
// stages, an input register and a result register, with the decode and one
// 32-bit pc adder between them. A beat passes from the input register to
// the result register, where it can be taken; throughput is one beat per
// cycle, limited only by the result side's stall. A stalled result holds
// while the input register keeps its beat, so no beat is dropped or
// repeated.
module rv32im_instruction_decoder_unit
  import rv32dec_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [31:0]        in_instr_word,
  input  logic [31:0]        in_pc,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [5:0]         out_mnemonic,
  output logic [4:0]         out_dest_reg,
  output logic [4:0]         out_src1_reg,
  output logic [4:0]         out_src2_reg,
  output logic signed [31:0] out_immediate,
  output logic [31:0]        out_target,
  output logic [11:0]        out_csr_address,
  output logic [3:0]         out_csr_name
);

  // Input register stage
  logic        s1_valid_r;
  logic [31:0] s1_word_r;
  logic [31:0] s1_pc_r;

  // Result register stage
  logic        res_valid_r;
  dec_result_t res_r;

  // Handshake: the result register loads when it is empty or being drained;
  // the input register loads when empty or when its beat moves on.
  logic res_load;
  logic s1_load;

  assign res_load = s1_valid_r && (!res_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !res_load;
  assign s1_load  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_load) begin
      s1_valid_r <= 1'b1;
    end else if (res_load) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_word_r <= in_instr_word;
      s1_pc_r   <= in_pc;
    end
  end

  // ---------------------------------------------------------------------
  // Decode
  // ---------------------------------------------------------------------
  logic [31:0] w;
  logic [2:0]  f3;
  logic [11:0] top;
  logic [31:0] imm_i;
  logic [31:0] imm_s;
  logic [31:0] imm_b;
  logic [31:0] imm_j;
  logic [31:0] imm_u;
  logic [31:0] shamt_ext;
  logic [31:0] zimm_ext;

  assign w         = s1_word_r;
  assign f3        = w[14:12];
  assign top       = w[31:20];
  assign imm_i     = {{20{w[31]}}, w[31:20]};
  assign imm_s     = {{20{w[31]}}, w[31:25], w[11:7]};
  assign imm_b     = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
  assign imm_j     = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
  assign imm_u     = w & UIMM_MASK;
  assign shamt_ext = {27'd0, w[24:20]};
  assign zimm_ext  = {27'd0, w[19:15]};

  logic [5:0]  mn;
  logic [31:0] imm;
  logic        use_tgt;
  logic        is_csr;
  dec_result_t res_nxt;

  always_comb begin
    mn      = MN_NONE;
    imm     = 32'd0;
    use_tgt = 1'b0;
    is_csr  = 1'b0;
    case (w[6:0])
      OP_LUI: begin
        mn  = MN_LUI;
        imm = imm_u;
      end
      OP_AUIPC: begin
        mn      = MN_AUIPC;
        imm     = imm_u;
        use_tgt = 1'b1;
      end
      OP_JAL: begin
        mn      = MN_JAL;
        imm     = imm_j;
        use_tgt = 1'b1;
      end
      OP_JALR: begin
        mn  = MN_JALR;
        imm = imm_i;
      end
      OP_BRANCH: begin
        case (f3)
          3'd0:    mn = MN_BEQ;
          3'd1:    mn = MN_BNE;
          3'd4:    mn = MN_BLT;
          3'd5:    mn = MN_BGE;
          3'd6:    mn = MN_BLTU;
          3'd7:    mn = MN_BGEU;
          default: mn = MN_NONE;
        endcase
        if (mn != MN_NONE) begin
          imm     = imm_b;
          use_tgt = 1'b1;
        end
      end
      OP_LOAD: begin
        case (f3)
          3'd0:    mn = MN_LB;
          3'd1:    mn = MN_LH;
          3'd2:    mn = MN_LW;
          3'd4:    mn = MN_LBU;
          3'd5:    mn = MN_LHU;
          default: mn = MN_NONE;
        endcase
        if (mn != MN_NONE) begin
          imm = imm_i;
        end
      end
      OP_STORE: begin
        case (f3)
          3'd0:    mn = MN_SB;
          3'd1:    mn = MN_SH;
          3'd2:    mn = MN_SW;
          default: mn = MN_NONE;
        endcase
        if (mn != MN_NONE) begin
          imm = imm_s;
        end
      end
      OP_IMM: begin
        imm = imm_i;
        case (f3)
          3'd0: mn = MN_ADDI;
          3'd1: begin
            mn  = MN_SLLI;
            imm = shamt_ext;
          end
          3'd2: mn = MN_SLTI;
          3'd3: mn = MN_SLTIU;
          3'd4: mn = MN_XORI;
          3'd5: begin
            mn  = w[30] ? MN_SRAI : MN_SRLI;
            imm = shamt_ext;
          end
          3'd6:    mn = MN_ORI;
          default: mn = MN_ANDI;
        endcase
      end
      OP_REG: begin
        if (w[31:25] == F7_MULDIV) begin
          mn = MN_MUL + {3'd0, f3};
        end else begin
          case (f3)
            3'd0:    mn = w[30] ? MN_SUB : MN_ADD;
            3'd1:    mn = MN_SLL;
            3'd2:    mn = MN_SLT;
            3'd3:    mn = MN_SLTU;
            3'd4:    mn = MN_XOR;
            3'd5:    mn = w[30] ? MN_SRA : MN_SRL;
            3'd6:    mn = MN_OR;
            default: mn = MN_AND;
          endcase
        end
      end
      OP_FENCE: mn = MN_FENCE;
      OP_SYSTEM: begin
        case (f3)
          3'd0: begin
            if (top == F12_ECALL) begin
              mn = MN_ECALL;
            end else if (top == F12_EBREAK) begin
              mn = MN_EBREAK;
            end else if (top == F12_MRET) begin
              mn = MN_MRET;
            end
          end
          3'd1: begin
            mn     = MN_CSRRW;
            is_csr = 1'b1;
          end
          3'd2: begin
            mn     = MN_CSRRS;
            is_csr = 1'b1;
          end
          3'd3: begin
            mn     = MN_CSRRC;
            is_csr = 1'b1;
          end
          3'd5: begin
            mn     = MN_CSRRWI;
            imm    = zimm_ext;
            is_csr = 1'b1;
          end
          3'd6: begin
            mn     = MN_CSRRSI;
            imm    = zimm_ext;
            is_csr = 1'b1;
          end
          3'd7: begin
            mn     = MN_CSRRCI;
            imm    = zimm_ext;
            is_csr = 1'b1;
          end
          default: mn = MN_NONE;
        endcase
      end
      default: mn = MN_NONE;
    endcase

    res_nxt.mnemonic    = mn;
    res_nxt.dest_reg    = w[11:7];
    res_nxt.src1_reg    = w[19:15];
    res_nxt.src2_reg    = w[24:20];
    res_nxt.immediate   = imm;
    // pc-relative target, wraps mod 2^32
    res_nxt.target      = use_tgt ? (s1_pc_r + imm) : 32'd0;
    res_nxt.csr_address = is_csr ? top : 12'd0;
    res_nxt.csr_name    = is_csr ? csr_index(top) : CSRN_UNKNOWN;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (res_load) begin
      res_valid_r <= 1'b1;
    end else if (!out_stall) begin
      res_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid       = res_valid_r;
  assign out_mnemonic    = res_r.mnemonic;
  assign out_dest_reg    = res_r.dest_reg;
  assign out_src1_reg    = res_r.src1_reg;
  assign out_src2_reg    = res_r.src2_reg;
  assign out_immediate   = $signed(res_r.immediate);
  assign out_target      = res_r.target;
  assign out_csr_address = res_r.csr_address;
  assign out_csr_name    = res_r.csr_name;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  // An unsupported word carries no immediate, target or CSR info.
  a_unsup_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_mnemonic == MN_NONE) |->
      (out_immediate == 32'sd0 && out_target == 32'd0 &&
       out_csr_address == 12'd0 && out_csr_name == CSRN_UNKNOWN))
    else $error("unsupported decode leaked payload");

  // A known CSR name only appears on CSR ops.
  a_csr_name_op: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_csr_name != CSRN_UNKNOWN) |->
      (out_mnemonic >= MN_CSRRW && out_mnemonic <= MN_CSRRCI))
    else $error("csr name on non-CSR op");

  // A nonzero target only comes from auipc, jal or a branch.
  a_target_op: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_target != 32'd0) |->
      (out_mnemonic == MN_AUIPC || out_mnemonic == MN_JAL ||
       (out_mnemonic >= MN_BEQ && out_mnemonic <= MN_BGEU)))
    else $error("target on non-relative op");

  // A held input beat that is not stalled moves into the result register.
  a_s1_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !in_stall) |=> out_valid)
    else $error("input beat lost");

  // While the result is stalled, the input beat is not overwritten.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && res_valid_r && out_stall) |=>
      (s1_valid_r && $stable(s1_word_r) && $stable(s1_pc_r)))
    else $error("input register overwritten under stall");

endmodule

@@ sim/tb_rv32im_instruction_decoder_unit.sv @@
// Testbench for the RV32IM instruction decoder: directed table, random beats, own decode check.
module tb_rv32im_instruction_decoder_unit;
  import rv32dec_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Quiet cycles (nothing accepted on either side) before we call it a hang.
  localparam int WATCHDOG_LIMIT = 1000;
  // Length of the long receiver hold-off used to back the block up.
  localparam int HOLD_CYCLES = 60;
  localparam int N_DIRECTED = 27;

  // Mnemonic lookup by funct3, lowest funct3 in the lowest slice.
  localparam logic [47:0] BRANCH_MN = {MN_BGEU, MN_BLTU, MN_BGE, MN_BLT,
                                       MN_NONE, MN_NONE, MN_BNE, MN_BEQ};
  localparam logic [47:0] LOAD_MN   = {MN_NONE, MN_NONE, MN_LHU, MN_LBU,
                                       MN_NONE, MN_LW, MN_LH, MN_LB};
  localparam logic [47:0] STORE_MN  = {MN_NONE, MN_NONE, MN_NONE, MN_NONE,
                                       MN_NONE, MN_SW, MN_SH, MN_SB};
  localparam logic [47:0] OPIMM_MN  = {MN_ANDI, MN_ORI, MN_SRLI, MN_XORI,
                                       MN_SLTIU, MN_SLTI, MN_SLLI, MN_ADDI};
  localparam logic [47:0] OPREG_MN  = {MN_AND, MN_OR, MN_SRL, MN_XOR,
                                       MN_SLTU, MN_SLT, MN_SLL, MN_ADD};
  localparam logic [47:0] CSR_MN    = {MN_CSRRCI, MN_CSRRSI, MN_CSRRWI, MN_NONE,
                                       MN_CSRRC, MN_CSRRS, MN_CSRRW, MN_NONE};

  // Pools the random generator draws from.
  localparam logic [76:0] OPCODE_POOL = {OP_LUI, OP_AUIPC, OP_JAL, OP_JALR, OP_BRANCH,
                                         OP_LOAD, OP_STORE, OP_IMM, OP_REG, OP_FENCE,
                                         OP_SYSTEM};
  localparam logic [131:0] CSR_POOL = {CSRA_MSTATUS, CSRA_MIE, CSRA_MTVEC, CSRA_MSCRATCH,
                                       CSRA_MEPC, CSRA_MCAUSE, CSRA_MTVAL, CSRA_MIP,
                                       CSRA_MASIC, CSRA_MCYCLE, CSRA_MCYCLEH};

  // One row of the directed table: instruction, pc, and a hand-written
  // expectation where it is obvious (otherwise the decode model is used).
  typedef struct packed {
    logic [31:0] word;
    logic [31:0] pc;
    logic        has_want;
    dec_result_t want;
  } instr_case_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [31:0]        in_instr_word = '0;
  logic [31:0]        in_pc = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [5:0]         out_mnemonic;
  logic [4:0]         out_dest_reg;
  logic [4:0]         out_src1_reg;
  logic [4:0]         out_src2_reg;
  logic signed [31:0] out_immediate;
  logic [31:0]        out_target;
  logic [11:0]        out_csr_address;
  logic [3:0]         out_csr_name;

  dec_result_t pending_decodes [$];
  int          mismatch_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  bit          hold_req = 1'b0;
  int          hold_left = 0;
  int          quiet_cycles = 0;

  instr_case_t directed_cases [N_DIRECTED] = '{
    // all-zero and all-one words are not instructions; raw fields still show
    '{32'h0000_0000, 32'h0000_0000, 1'b1,
      '{MN_NONE, 5'd0, 5'd0, 5'd0, 32'h0, 32'h0, 12'h0, CSRN_UNKNOWN}},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
      '{MN_NONE, 5'd31, 5'd31, 5'd31, 32'h0, 32'h0, 12'h0, CSRN_UNKNOWN}},
    // lui with every upper bit set
    '{32'hFFFF_F0B7, 32'h1234_5678, 1'b1,
      '{MN_LUI, 5'd1, 5'd31, 5'd31, 32'hFFFF_F000, 32'h0, 12'h0, CSRN_UNKNOWN}},
    '{32'h8000_0297, 32'hFFFF_FFFF, 1'b0, '0},  // auipc, target wraps
    '{32'hFFFF_F0EF, 32'h0000_0000, 1'b0, '0},  // jal backward past zero
    '{32'h7FFF_FFEF, 32'hFFFF_F000, 1'b0, '0},  // jal largest forward offset
    '{32'h8001_0167, 32'h0000_0100, 1'b0, '0},  // jalr most negative imm
    '{32'hFFFF_FFE3, 32'h0000_0000, 1'b0, '0},  // bgeu, all offset bits set
    '{32'h7E00_0FE3, 32'h7FFF_F000, 1'b0, '0},  // beq largest forward offset
    // branch with a reserved funct3
    '{32'h0000_2063, 32'h0000_1000, 1'b1,
      '{MN_NONE, 5'd0, 5'd0, 5'd0, 32'h0, 32'h0, 12'h0, CSRN_UNKNOWN}},
    '{32'h8000_4003, 32'h0000_0000, 1'b0, '0},  // lbu
    // load with a reserved funct3
    '{32'h0000_7003, 32'h0000_0004, 1'b1,
      '{MN_NONE, 5'd0, 5'd0, 5'd0, 32'h0, 32'h0, 12'h0, CSRN_UNKNOWN}},
    '{32'hFE0F_AFA3, 32'h0000_0008, 1'b0, '0},  // sw
    // store with a reserved funct3
    '{32'h0000_3023, 32'h0000_000C, 1'b1,
      '{MN_NONE, 5'd0, 5'd0, 5'd0, 32'h0, 32'h0, 12'h0, CSRN_UNKNOWN}},
    '{32'h7FF0_0013, 32'h0000_0010, 1'b0, '0},  // addi max positive
    '{32'h41F0_D093, 32'h0000_0014, 1'b0, '0},  // srai shamt 31
    '{32'hBE00_D013, 32'h0000_0018, 1'b0, '0},  // srli, funct7 junk, bit 30 clear
    '{32'h0200_F033, 32'h0000_001C, 1'b0, '0},  // remu
    '{32'hC200_5033, 32'h0000_0020, 1'b0, '0},  // funct7 not 1 -> base op, sra via bit 30
    '{32'hFFFF_F00F, 32'h0000_0024, 1'b0, '0},  // fence, funct3 ignored
    // ecall: nothing but the mnemonic
    '{32'h0000_0073, 32'hFFFF_FFFC, 1'b1,
      '{MN_ECALL, 5'd0, 5'd0, 5'd0, 32'h0, 32'h0, 12'h0, CSRN_UNKNOWN}},
    '{32'h3020_0073, 32'h0000_0028, 1'b0, '0},  // mret
    '{32'h000F_8F73, 32'h0000_002C, 1'b0, '0},  // ecall with rd/rs1 set
    '{32'h3050_1073, 32'h0000_0030, 1'b0, '0},  // csrrw mtvec
    '{32'hB80F_F073, 32'h0000_0034, 1'b0, '0},  // csrrci mcycleh, zimm 31
    '{32'hFFF0_2073, 32'h0000_0038, 1'b0, '0},  // csrrs on unknown csr
    // system with funct3 4 is reserved
    '{32'h0000_4073, 32'h0000_003C, 1'b1,
      '{MN_NONE, 5'd0, 5'd0, 5'd0, 32'h0, 32'h0, 12'h0, CSRN_UNKNOWN}}
  };

  rv32im_instruction_decoder_unit dut (.*);

  always #10 clk = ~clk;

  // Expected decode of one instruction word.
  function automatic dec_result_t decode_rv32(input logic [31:0] w, input logic [31:0] pc);
    dec_result_t r;
    logic [2:0]  f3;
    logic [31:0] iimm;
    r = '0;
    f3 = w[14:12];
    iimm = {{20{w[31]}}, w[31:20]};
    r.dest_reg = w[11:7];
    r.src1_reg = w[19:15];
    r.src2_reg = w[24:20];
    case (w[6:0])
      OP_LUI: begin
        r.mnemonic = MN_LUI;
        r.immediate = w & UIMM_MASK;
      end
      OP_AUIPC: begin
        r.mnemonic = MN_AUIPC;
        r.immediate = w & UIMM_MASK;
        r.target = pc + r.immediate;
      end
      OP_JAL: begin
        r.mnemonic = MN_JAL;
        r.immediate = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
        r.target = pc + r.immediate;
      end
      OP_JALR: begin
        r.mnemonic = MN_JALR;
        r.immediate = iimm;
      end
      OP_BRANCH: begin
        r.mnemonic = BRANCH_MN[6*f3 +: 6];
        if (r.mnemonic != MN_NONE) begin
          r.immediate = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
          r.target = pc + r.immediate;
        end
      end
      OP_LOAD: begin
        r.mnemonic = LOAD_MN[6*f3 +: 6];
        if (r.mnemonic != MN_NONE) r.immediate = iimm;
      end
      OP_STORE: begin
        r.mnemonic = STORE_MN[6*f3 +: 6];
        if (r.mnemonic != MN_NONE) r.immediate = {{20{w[31]}}, w[31:25], w[11:7]};
      end
      OP_IMM: begin
        r.mnemonic = OPIMM_MN[6*f3 +: 6];
        if (r.mnemonic == MN_SRLI && w[30]) r.mnemonic = MN_SRAI;
        if (r.mnemonic == MN_SLLI || r.mnemonic == MN_SRLI || r.mnemonic == MN_SRAI)
          r.immediate = {27'b0, w[24:20]};
        else
          r.immediate = iimm;
      end
      OP_REG: begin
        if (w[31:25] == F7_MULDIV) begin
          r.mnemonic = MN_MUL + {3'b0, f3};
        end else begin
          r.mnemonic = OPREG_MN[6*f3 +: 6];
          if (w[30] && r.mnemonic == MN_ADD) r.mnemonic = MN_SUB;
          if (w[30] && r.mnemonic == MN_SRL) r.mnemonic = MN_SRA;
        end
      end
      OP_FENCE: r.mnemonic = MN_FENCE;
      OP_SYSTEM: begin
        if (f3 == '0) begin
          case (w[31:20])
            F12_ECALL:  r.mnemonic = MN_ECALL;
            F12_EBREAK: r.mnemonic = MN_EBREAK;
            F12_MRET:   r.mnemonic = MN_MRET;
            default:    r.mnemonic = MN_NONE;
          endcase
        end else begin
          r.mnemonic = CSR_MN[6*f3 +: 6];
          if (r.mnemonic != MN_NONE) begin
            r.csr_address = w[31:20];
            case (w[31:20])
              CSRA_MSTATUS:  r.csr_name = CSRN_MSTATUS;
              CSRA_MIE:      r.csr_name = CSRN_MIE;
              CSRA_MTVEC:    r.csr_name = CSRN_MTVEC;
              CSRA_MSCRATCH: r.csr_name = CSRN_MSCRATCH;
              CSRA_MEPC:     r.csr_name = CSRN_MEPC;
              CSRA_MCAUSE:   r.csr_name = CSRN_MCAUSE;
              CSRA_MTVAL:    r.csr_name = CSRN_MTVAL;
              CSRA_MIP:      r.csr_name = CSRN_MIP;
              CSRA_MASIC:    r.csr_name = CSRN_MASIC;
              CSRA_MCYCLE:   r.csr_name = CSRN_MCYCLE;
              CSRA_MCYCLEH:  r.csr_name = CSRN_MCYCLEH;
              default:       r.csr_name = CSRN_UNKNOWN;
            endcase
            // immediate forms carry zimm in the rs1 slot
            if (w[14]) r.immediate = {27'b0, w[19:15]};
          end
        end
      end
      default: r.mnemonic = MN_NONE;
    endcase
    return r;
  endfunction

  // Offer one beat, optionally after a random idle gap, and log what it should decode to.
  // in_valid is only lowered when a gap is actually taken, so a back-to-back
  // beat never sees two assignments in the same step.
  task automatic send_instr(input logic [31:0] word, input logic [31:0] pc,
                            input logic has_want, input dec_result_t want);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_instr_word <= word;
    in_pc <= pc;
    // values read right after the edge are the ones the DUT sampled
    do @(posedge clk); while (in_stall);
    pending_decodes.push_back(has_want ? want : decode_rv32(word, pc));
  endtask

  // Random beats: mostly well-formed opcodes with random fields, some noise.
  task automatic send_random(input int count);
    logic [31:0] word;
    logic [31:0] pc;
    logic [6:0]  opc;
    int          pick;
    repeat (count) begin
      word = $urandom;
      pick = $urandom_range(99);
      if (pick >= 8) begin
        opc = OPCODE_POOL[7*$urandom_range(10) +: 7];
        word[6:0] = opc;
        if (opc == OP_REG) begin
          // steer funct7 toward the M group and the plain base group
          pick = $urandom_range(2);
          if (pick == 0) word[31:25] = F7_MULDIV;
          else if (pick == 1) word[31:25] = {1'b0, word[30], 5'b0};
        end
        if (opc == OP_SYSTEM) begin
          pick = $urandom_range(9);
          if (pick < 3) begin
            word[14:12] = '0;
            word[31:20] = (pick == 0) ? F12_ECALL : (pick == 1) ? F12_EBREAK : F12_MRET;
          end else if (pick < 7) begin
            word[31:20] = CSR_POOL[12*$urandom_range(10) +: 12];
          end
        end
      end
      pc = $urandom;
      pick = $urandom_range(19);
      if (pick == 0) pc = '0;
      else if (pick == 1) pc = '1;
      else if (pick == 2) pc = 32'h8000_0000;
      send_instr(word, pc, 1'b0, '0);
    end
  endtask

  // Stop offering and wait for every outstanding beat to come back.
  task automatic drain_decodes();
    in_valid <= 1'b0;
    while (pending_decodes.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endtask

  // Result side: score the accepted beat, then pick the stall for the next
  // cycle. A long hold-off is requested by the stimulus and counted here.
  always @(posedge clk) begin : result_side
    dec_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_decodes.size() == 0) begin
        $error("result beat with no instruction outstanding: mnemonic 0x%0h", out_mnemonic);
        mismatch_count++;
      end else begin
        want = pending_decodes.pop_front();
        check_field("mnemonic", 32'(want.mnemonic), 32'(out_mnemonic));
        check_field("dest_reg", 32'(want.dest_reg), 32'(out_dest_reg));
        check_field("src1_reg", 32'(want.src1_reg), 32'(out_src1_reg));
        check_field("src2_reg", 32'(want.src2_reg), 32'(out_src2_reg));
        check_field("immediate", want.immediate, out_immediate);
        check_field("target", want.target, out_target);
        check_field("csr_address", 32'(want.csr_address), 32'(out_csr_address));
        check_field("csr_name", 32'(want.csr_name), 32'(out_csr_name));
      end
    end
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog: any cycle with a beat on either side resets the count.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed table, no idling on either side
    foreach (directed_cases[i])
      send_instr(directed_cases[i].word, directed_cases[i].pc,
                 directed_cases[i].has_want, directed_cases[i].want);

    // random phases: none, sender idle, receiver stalling, both
    send_random(140);
    send_idle_pct = 69;
    send_random(140);
    send_idle_pct = 0;
    recv_stall_pct = 69;
    send_random(140);
    send_idle_pct = 37;
    recv_stall_pct = 37;
    send_random(140);

    // back the block up: receiver holds off while beats keep coming
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = 1'b1;
    send_random(30);

    // full pause until everything is back, then a last mixed run
    drain_decodes();
    send_idle_pct = 37;
    recv_stall_pct = 37;
    send_random(40);

    drain_decodes();
    // two-stage pipe; a final wait catches any stray result beat
    repeat (8) @(posedge clk);
    if (mismatch_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

@@ rv32im_instruction_decoder_unit.f @@
design/rv32dec_pkg.sv
design/rv32im_instruction_decoder_unit.sv
sim/tb_rv32im_instruction_decoder_unit.sv
